// ===== rtl/acrw_pkg.sv =====
// Package for the audio capture ring writer.
// Holds widths, register indexes, controller states and the structs shared
// by the register file, controller and datapath. No dependencies.
package acrw_pkg;

	localparam int unsigned SampleW  = 32;
	localparam int unsigned CountW   = 32;
	localparam int unsigned OffsetW  = 16;
	localparam int unsigned AddrW    = 32;
	localparam int unsigned InDataW  = 96;
	localparam int unsigned OutDataW = 144;
	localparam int unsigned OutUserW = 3;
	localparam int unsigned CfgAddrW = 5;
	localparam int unsigned CfgDataW = 32;

	// The header offset is reduced from offset + advance + capacity, which needs 18 bits.
	localparam int unsigned NumW     = OffsetW + 2;
	localparam int unsigned RemW     = OffsetW + 1;
	localparam int unsigned DivSteps = NumW;
	localparam int unsigned DivCntW  = $clog2(DivSteps);

	typedef enum logic [2:0] {
		REG_CAPTURE_EN = 3'd0,
		REG_CAPACITY   = 3'd1,
		REG_START      = 3'd2,
		REG_ADVANCE    = 3'd3,
		REG_BLOCK_LEN  = 3'd4,
		REG_BASE       = 3'd5
	} acrw_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CNT1,
		ST_CNT2,
		ST_DIV,
		ST_FIN
	} acrw_state_t;

	typedef struct packed {
		logic               capture_en;
		logic [OffsetW-1:0] capacity;
		logic [OffsetW-1:0] start_offset;
		logic [OffsetW-1:0] advance;
		logic [OffsetW-1:0] block_len;
		logic [AddrW-1:0]   base;
	} acrw_cfg_t;

	typedef struct packed {
		logic accept;
		logic cnt1;
		logic cnt2;
		logic div_step;
		logic finish;
	} acrw_cmd_t;

	typedef struct packed {
		logic need_adv;
	} acrw_status_t;

endpackage

// ===== rtl/audio_capture_ring_writer.sv =====
// Audio capture ring writer, top level.
// Instantiates acrw_regs, acrw_ctrl and acrw_dp; depends on acrw_pkg.
//
// Samples enter on the s_ stream, one per transfer, and are grouped into
// blocks of the configured length. Every accepted sample gives exactly one
// result on the m_ stream: a ring memory write (address and data) when the
// block is captured, and at the block's last sample the header write-back
// with tlast set. Configuration is to be written over the APB-style port
// only while the block is idle; the block itself does not enforce this.
// Unless a header update follows, a result is registered and shown in the
// cycle after its sample is accepted, and samples are taken one per cycle
// while the receiver keeps up. A captured block's last sample with a nonzero
// header advance gives its result after the count update (CNT1, CNT2), the
// bit-serial reduction of the header offset modulo the ring capacity, one bit
// per cycle, and the result load in FIN; meanwhile no sample is accepted.
// The output register lets a new sample be accepted in the cycle in which
// the previous result is taken; while the receiver stalls with a result
// waiting, the input is held off. Reset clears the header, ring index, block
// position and all configuration registers (block length reads as one).
module audio_capture_ring_writer import acrw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output logic [CfgDataW-1:0] prdata,
	output logic                pready,
	input  logic                s_tvalid,
	output logic                s_tready,
	// sample[31:0], host_total_count[63:32], host_lost_count[95:64]
	input  logic [InDataW-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// write_address[31:0], sample_data[63:32], new_write_offset[79:64],
	// new_total_count[111:80], new_lost_count[143:112]
	output logic [OutDataW-1:0] m_tdata,
	// write_valid[0], header_valid[1], header_cleared[2]
	output logic [OutUserW-1:0] m_tuser,
	output logic                m_tlast
);

	acrw_cfg_t    cfg;
	acrw_cmd_t    cmd;
	acrw_status_t status;

	acrw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	acrw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	acrw_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (cmd),
		.status  (status),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// ===== rtl/acrw_regs.sv =====
// Configuration register file with an APB-style port.
// Depends on acrw_pkg for the register indexes and the configuration struct.
module acrw_regs import acrw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [CfgDataW-1:0] pwdata,
	output logic [CfgDataW-1:0] prdata,
	output logic                pready,
	output acrw_cfg_t           cfg
);

	acrw_cfg_t  cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[CfgAddrW-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capture_en   <= 1'b0;
			cfg_q.capacity     <= '0;
			cfg_q.start_offset <= '0;
			cfg_q.advance      <= '0;
			cfg_q.block_len    <= OffsetW'(1);
			cfg_q.base         <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_CAPTURE_EN: cfg_q.capture_en   <= pwdata[0];
				REG_CAPACITY:   cfg_q.capacity     <= pwdata[OffsetW-1:0];
				REG_START:      cfg_q.start_offset <= pwdata[OffsetW-1:0];
				REG_ADVANCE:    cfg_q.advance      <= pwdata[OffsetW-1:0];
				REG_BLOCK_LEN:  cfg_q.block_len    <= pwdata[OffsetW-1:0];
				REG_BASE:       cfg_q.base         <= pwdata[AddrW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CAPTURE_EN: prdata = {{(CfgDataW-1){1'b0}}, cfg_q.capture_en};
			REG_CAPACITY:   prdata = {{(CfgDataW-OffsetW){1'b0}}, cfg_q.capacity};
			REG_START:      prdata = {{(CfgDataW-OffsetW){1'b0}}, cfg_q.start_offset};
			REG_ADVANCE:    prdata = {{(CfgDataW-OffsetW){1'b0}}, cfg_q.advance};
			REG_BLOCK_LEN:  prdata = {{(CfgDataW-OffsetW){1'b0}}, cfg_q.block_len};
			REG_BASE:       prdata = cfg_q.base;
			default:        prdata = '0;
		endcase
	end

endmodule

// ===== rtl/acrw_ctrl.sv =====
// Controller state machine for the audio capture ring writer.
// Sequences transfers, the header count update and the offset reduction.
// Depends on acrw_pkg for states, commands and status.
module acrw_ctrl import acrw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  acrw_status_t status,
	output acrw_cmd_t    cmd
);

	localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

	acrw_state_t        state_q, state_d;
	logic [DivCntW-1:0] div_cnt_q;
	logic               out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = !out_valid_q || m_tready;
				cmd.accept = s_tvalid && s_tready;
				if (cmd.accept && status.need_adv) begin
					state_d = ST_CNT1;
				end
			end
			ST_CNT1: begin
				cmd.cnt1 = 1'b1;
				state_d  = ST_CNT2;
			end
			ST_CNT2: begin
				cmd.cnt2 = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DivLast) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			div_cnt_q <= div_cnt_q + DivCntW'(1);
		end else begin
			div_cnt_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.accept && !status.need_adv) || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

`ifndef SYNTHESIS
	a_adv_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && status.need_adv |=> !out_valid_q)
		else $error("result shown before the header update finished");
	a_fin_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |=> out_valid_q && state_q == ST_IDLE)
		else $error("header update finished without a result");
	a_div_starts_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CNT2 |=> state_q == ST_DIV && div_cnt_q == '0)
		else $error("offset reduction started with a stale step count");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !cmd.accept)
		else $error("transfer accepted during the header update");
`endif

endmodule

// ===== rtl/acrw_dp.sv =====
// Datapath for the audio capture ring writer: block and ring state, header
// registers, the count update, a bit-serial offset reduction and the output register.
// Depends on acrw_pkg; driven by commands from acrw_ctrl.
module acrw_dp import acrw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  acrw_cfg_t           cfg,
	input  acrw_cmd_t           cmd,
	output acrw_status_t        status,
	input  logic [InDataW-1:0]  s_tdata,
	output logic [OutDataW-1:0] m_tdata,
	output logic [OutUserW-1:0] m_tuser,
	output logic                m_tlast
);

	logic signed [SampleW-1:0] sample;
	logic [CountW-1:0]         host_total, host_lost;

	logic [OffsetW-1:0] hoff_q, ridx_q, pos_q;
	logic [CountW-1:0]  htot_q, hlost_q, lat_t_q, lat_l_q;
	logic               acc_q, dis_q;

	logic [CountW-1:0]  diff_q, lost_sum_q, total_sum_q;
	logic               lost_upd_q;
	logic [NumW-1:0]    num_q;
	logic [RemW-1:0]    rem_q;

	logic                      o_wv_q, o_hv_q, o_hc_q, o_last_q;
	logic [AddrW-1:0]          o_addr_q;
	logic signed [SampleW-1:0] o_data_q;
	logic [OffsetW-1:0]        o_off_q;
	logic [CountW-1:0]         o_tot_q, o_lost_q;

	logic               first_blk, acc_new, acc_e, dis_e, last;
	logic [RemW-1:0]    first_sum, cap_w, pos_inc, ri_inc, rem_sh;
	logic [OffsetW-1:0] first_slot, ri_e, ri_next, len, off_new;
	logic [AddrW-1:0]   addr;
	logic [CountW-1:0]  cap_c, adv_c, diff;

	assign sample     = s_tdata[SampleW-1:0];
	assign host_total = s_tdata[SampleW+CountW-1:SampleW];
	assign host_lost  = s_tdata[InDataW-1:SampleW+CountW];

	assign cap_w      = {1'b0, cfg.capacity};
	assign cap_c      = {{(CountW-OffsetW){1'b0}}, cfg.capacity};
	assign adv_c      = {{(CountW-OffsetW){1'b0}}, cfg.advance};
	assign first_blk  = pos_q == '0;
	assign first_sum  = {1'b0, hoff_q} + {1'b0, cfg.start_offset};
	assign acc_new    = cfg.capture_en && cfg.capacity != '0 && cfg.block_len != '0 &&
	                    cfg.block_len <= cfg.capacity && first_sum <= cap_w;
	assign acc_e      = first_blk ? acc_new : acc_q;
	assign dis_e      = first_blk ? !cfg.capture_en : dis_q;
	assign first_slot = (first_sum == cap_w) ? '0 : first_sum[OffsetW-1:0];
	assign ri_e       = (first_blk && acc_new) ? first_slot : ridx_q;
	assign len        = (cfg.block_len == '0) ? OffsetW'(1) : cfg.block_len;
	assign pos_inc    = {1'b0, pos_q} + RemW'(1);
	assign last       = pos_inc >= {1'b0, len};
	assign ri_inc     = {1'b0, ri_e} + RemW'(1);
	assign ri_next    = (ri_inc >= cap_w) ? '0 : ri_inc[OffsetW-1:0];
	assign addr       = cfg.base + {{(AddrW-OffsetW-2){1'b0}}, ri_e, 2'b00};
	assign diff       = htot_q - lat_t_q;
	assign rem_sh     = {rem_q[RemW-2:0], num_q[NumW-1]};
	assign off_new    = (cfg.capacity != '0) ? rem_q[OffsetW-1:0] : hoff_q;

	assign status.need_adv = acc_e && last && cfg.advance != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hoff_q  <= '0;
			htot_q  <= '0;
			hlost_q <= '0;
			ridx_q  <= '0;
			pos_q   <= '0;
			acc_q   <= 1'b0;
			dis_q   <= 1'b0;
			lat_t_q <= '0;
			lat_l_q <= '0;
		end else begin
			if (cmd.accept) begin
				if (first_blk) begin
					lat_t_q <= host_total;
					lat_l_q <= host_lost;
					acc_q   <= acc_new;
					dis_q   <= !cfg.capture_en;
				end
				if (acc_e) begin
					ridx_q <= ri_next;
				end
				pos_q <= last ? '0 : pos_inc[OffsetW-1:0];
				if (last && !acc_e && dis_e) begin
					hoff_q <= '0;
					htot_q <= '0;
				end
			end
			if (cmd.cnt2) begin
				if (lost_upd_q) begin
					hlost_q <= ((lost_sum_q - lat_l_q) < (hlost_q - lat_l_q)) ?
					           lat_l_q - CountW'(1) : lost_sum_q;
				end
				htot_q <= ((total_sum_q - lat_t_q) < diff_q) ?
				          lat_t_q - CountW'(1) : total_sum_q;
			end
			if (cmd.finish) begin
				hoff_q <= off_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cnt1) begin
			diff_q      <= diff;
			lost_upd_q  <= diff >= cap_c;
			lost_sum_q  <= hlost_q + adv_c;
			total_sum_q <= htot_q + adv_c;
			num_q       <= {2'b00, hoff_q} + {2'b00, cfg.advance} + {2'b00, cfg.capacity};
			rem_q       <= '0;
		end else if (cmd.div_step) begin
			rem_q <= (rem_sh >= cap_w) ? rem_sh - cap_w : rem_sh;
			num_q <= {num_q[NumW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			o_wv_q   <= acc_e;
			o_addr_q <= acc_e ? addr : '0;
			o_data_q <= acc_e ? sample : '0;
			o_last_q <= last;
			o_hv_q   <= last && (acc_e || dis_e);
			o_hc_q   <= last && !acc_e && dis_e;
			o_off_q  <= (last && acc_e) ? hoff_q : '0;
			o_tot_q  <= (last && acc_e) ? htot_q : '0;
			o_lost_q <= (last && (acc_e || dis_e)) ? hlost_q : '0;
		end else if (cmd.finish) begin
			o_off_q  <= off_new;
			o_tot_q  <= htot_q;
			o_lost_q <= hlost_q;
		end
	end

	assign m_tdata = {o_lost_q, o_tot_q, o_off_q, o_data_q, o_addr_q};
	assign m_tuser = {o_hc_q, o_hv_q, o_wv_q};
	assign m_tlast = o_last_q;

endmodule
